>>> hdl/process_id_allocator_macros.svh
// assertion macros used by the process id allocator checker
`ifndef PROCESS_ID_ALLOCATOR_MACROS_SVH
`define PROCESS_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication, off while reset is high
`define PIDA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define PIDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pida_pkg.sv
// shared constants and types of the process id allocator
package pida_pkg;

  localparam int PID_W     = 10;
  localparam int PID_SPACE = 1 << PID_W;
  localparam int MAX_PROCS = 32;
  localparam int OWNER_W   = 16;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int NUM_WORDS = PID_SPACE / WORD_BITS;
  localparam int WIDX_W    = $clog2(NUM_WORDS);
  localparam int CNT_W     = $clog2(NUM_WORDS + 1);
  localparam int LIVE_W    = $clog2(MAX_PROCS + 1);

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic scan;
    logic check;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       hit;
    logic       scan_last;
    logic       out_free;
  } sts_t;

endpackage

>>> hdl/pida_req_if.sv
// request channel: command, identifier and owner handle
interface pida_req_if;
  import pida_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [PID_W-1:0]   pid;
  logic [OWNER_W-1:0] owner;

  modport source (output valid, cmd, pid, owner, input ready);
  modport sink (input valid, cmd, pid, owner, output ready);
  modport monitor (input valid, ready, cmd, pid, owner);
endinterface

>>> hdl/pida_rsp_if.sv
// response channel: status, granted identifier and owner handle
interface pida_rsp_if;
  import pida_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [PID_W-1:0]   granted_pid;
  logic [OWNER_W-1:0] owner_out;

  modport source (output valid, status, granted_pid, owner_out, input ready);
  modport sink (input valid, status, granted_pid, owner_out, output ready);
  modport monitor (input valid, ready, status, granted_pid, owner_out);
endinterface

>>> hdl/pida_ctrl.sv
// controller state machine of the process id allocator
module pida_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pida_pkg::sts_t  sts,
  output pida_pkg::ctl_t  ctl
);
  import pida_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.cmd == CMD_ALLOC && !sts.full) begin
          state_next = S_SCAN;
        end else if (sts.cmd == CMD_RELEASE || sts.cmd == CMD_LOOKUP) begin
          state_next = S_CHECK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (sts.hit || sts.scan_last) state_next = S_FINISH;
      end
      S_CHECK: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      S_DECODE: ctl.start    = 1'b1;
      S_SCAN:   ctl.scan     = 1'b1;
      S_CHECK:  ctl.check    = 1'b1;
      S_FINISH: ctl.load_out = sts.out_free;
      default: begin
        ctl      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/pida_datapath.sv
// used map, owner table, counters and result registers
module pida_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  pida_pkg::ctl_t            ctl,
  output pida_pkg::sts_t            sts,
  input  logic [1:0]                in_cmd,
  input  logic [pida_pkg::PID_W-1:0]   in_pid,
  input  logic [pida_pkg::OWNER_W-1:0] in_owner,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [pida_pkg::PID_W-1:0]   out_pid,
  output logic [pida_pkg::OWNER_W-1:0] out_owner
);
  import pida_pkg::*;

  // lowest set bit of a word, used to pick the lowest free bit
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // captured item
  logic [1:0]         cmd_q;
  logic [PID_W-1:0]   pid_q;
  logic [OWNER_W-1:0] owner_q;

  logic [LIVE_W-1:0]  live_count;
  logic [PID_W-1:0]   last_granted;

  // used map as words, with one valid flag per word cleared by reset
  logic [WORD_BITS-1:0] used_mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid;
  logic [WORD_BITS-1:0] rd_word;
  logic                 rd_row_valid;

  logic [OWNER_W-1:0]   owner_mem [PID_SPACE];
  logic [OWNER_W-1:0]   owner_rd;

  logic [WIDX_W-1:0]    scan_addr;
  logic [CNT_W-1:0]     scan_cnt;

  logic [1:0]           res_status;
  logic [PID_W-1:0]     res_pid;
  logic [OWNER_W-1:0]   res_owner;

  logic [PID_W:0]       nxt_id;
  logic [PID_W-1:0]     start_id;
  logic [WIDX_W-1:0]    start_word;
  logic [BIT_W-1:0]     start_bit;
  logic [WORD_BITS-1:0] low_mask;
  logic [WORD_BITS-1:0] eff_word;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] free_vec;
  logic                 hit;
  logic [BIT_W-1:0]     found_bit;
  logic [PID_W-1:0]     found_id;
  logic [WIDX_W-1:0]    pid_word;
  logic [BIT_W-1:0]     pid_bit;
  logic                 pid_live;
  logic                 full;
  logic                 scan_last;
  logic [WIDX_W-1:0]    rd_addr;
  logic                 wr_alloc;
  logic                 wr_release;
  logic                 wr_en;
  logic [WIDX_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  always_comb begin
    // search starts after the last grant, wrapping to 1
    nxt_id     = {1'b0, last_granted} + (PID_W + 1)'(1);
    start_id   = nxt_id[PID_W] ? PID_W'(1) : nxt_id[PID_W-1:0];
    start_word = start_id[PID_W-1:BIT_W];
    start_bit  = start_id[BIT_W-1:0];
    low_mask   = (WORD_BITS'(1) << start_bit) - WORD_BITS'(1);

    eff_word = rd_row_valid ? rd_word : '0;

    // first visit: bits from the start up; last visit: bits below the start
    if (scan_cnt == '0) begin
      scan_mask = ~low_mask;
    end else if (scan_cnt == CNT_W'(NUM_WORDS)) begin
      scan_mask = low_mask;
    end else begin
      scan_mask = '1;
    end
    if (scan_addr == '0) scan_mask = scan_mask & ~WORD_BITS'(1);

    free_vec  = ~eff_word & scan_mask;
    hit       = |free_vec;
    found_bit = lowest_set(free_vec);
    found_id  = {scan_addr, found_bit};

    pid_word = pid_q[PID_W-1:BIT_W];
    pid_bit  = pid_q[BIT_W-1:0];
    pid_live = (pid_q != '0) && eff_word[pid_bit];

    full      = live_count >= LIVE_W'(MAX_PROCS);
    scan_last = scan_cnt == CNT_W'(NUM_WORDS);

    if (ctl.start) begin
      rd_addr = (cmd_q == CMD_ALLOC) ? start_word : pid_word;
    end else begin
      rd_addr = scan_addr + WIDX_W'(1);
    end

    wr_alloc   = ctl.scan && hit;
    wr_release = ctl.check && cmd_q == CMD_RELEASE && pid_live;
    wr_en      = wr_alloc || wr_release;
    wr_addr    = wr_alloc ? scan_addr : pid_word;
    wr_data    = wr_alloc ? (eff_word | (WORD_BITS'(1) << found_bit))
                          : (eff_word & ~(WORD_BITS'(1) << pid_bit));
  end

  always_comb begin
    sts.cmd       = cmd_q;
    sts.full      = full;
    sts.hit       = hit;
    sts.scan_last = scan_last;
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= in_cmd;
      pid_q   <= in_pid;
      owner_q <= in_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) used_mem[wr_addr] <= wr_data;
    rd_word      <= used_mem[rd_addr];
    rd_row_valid <= row_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_alloc) owner_mem[found_id] <= owner_q;
    owner_rd <= owner_mem[pid_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count   <= '0;
      last_granted <= '0;
    end else if (wr_alloc) begin
      live_count   <= live_count + LIVE_W'(1);
      last_granted <= found_id;
    end else if (wr_release) begin
      live_count   <= live_count - LIVE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      scan_addr <= start_word;
      scan_cnt  <= '0;
    end else if (ctl.scan) begin
      scan_addr <= scan_addr + WIDX_W'(1);
      scan_cnt  <= scan_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      res_status <= (cmd_q == CMD_ALLOC && full) ? ST_FULL : ST_OK;
      res_pid    <= '0;
      res_owner  <= '0;
    end else if (ctl.scan) begin
      if (hit) begin
        res_status <= ST_OK;
        res_pid    <= found_id;
      end else if (scan_last) begin
        res_status <= ST_FULL;
      end
    end else if (ctl.check) begin
      if (!pid_live) begin
        res_status <= ST_UNUSED;
      end else if (cmd_q == CMD_LOOKUP) begin
        res_owner <= owner_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status <= res_status;
      out_pid    <= res_pid;
      out_owner  <= res_owner;
    end
  end

endmodule

>>> hdl/process_id_allocator.sv
// top level of the process id allocator
// Hands out process identifiers 1 to 1023 (0 is reserved) to at most 32 live
// owners. One item is worked on at a time; the next one is accepted while the
// previous result still waits in the output register. An allocate scans the
// used map one 32-bit word at a time, up to 33 words (all 32 words, then the
// start word again for the bits below the search start), limited by the
// single read port of the used-map memory. A release or lookup checks one
// word; an allocate into a full pool or an unused command goes straight to
// the output load. The used map is cleared at reset through one valid flag per
// word, so no clearing pass is run and items are taken from the first cycle
// after reset.
module process_id_allocator (
  input logic        clk,
  input logic        rst,
  pida_req_if.sink   req,
  pida_rsp_if.source rsp
);
  import pida_pkg::*;

  // command and status between controller and datapath
  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  // sequencing: decode, word scan or single-word check, then output load
  pida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  assign req.ready = in_ready;

  // used map, owner table, live counter and output register
  pida_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (req.cmd),
    .in_pid     (req.pid),
    .in_owner   (req.owner),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_pid    (rsp.granted_pid),
    .out_owner  (rsp.owner_out)
  );

endmodule

>>> hdl/pida_checker.sv
// port-level checks of the process id allocator and their binding
`include "process_id_allocator_macros.svh"

module pida_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [1:0]                   rsp_status,
  input logic [pida_pkg::PID_W-1:0]   rsp_granted_pid,
  input logic [pida_pkg::OWNER_W-1:0] rsp_owner_out
);
  import pida_pkg::*;

  // a stalled result holds
  `PIDA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_status) && $stable(rsp_granted_pid) && $stable(rsp_owner_out),
    "stalled result changed")

  // one item at a time: no accept right after an accept
  `PIDA_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready,
    "ready right after accept")

  // a full pool grants nothing and returns no handle
  `PIDA_ASSERT_IMPLY(a_full_empty, clk, rst, rsp_valid && rsp_status == ST_FULL,
    rsp_granted_pid == '0 && rsp_owner_out == '0, "full result carries data")

  // an unused identifier returns no grant and no handle
  `PIDA_ASSERT_IMPLY(a_unused_empty, clk, rst, rsp_valid && rsp_status == ST_UNUSED,
    rsp_granted_pid == '0 && rsp_owner_out == '0, "unused result carries data")

endmodule

bind process_id_allocator pida_checker u_pida_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_granted_pid (rsp.granted_pid),
  .rsp_owner_out   (rsp.owner_out)
);
